// ----- rtl/core/median_filter_3x3_clamped_macros.svh -----
// Assertion macros shared by the median filter modules.
`ifndef MEDIAN_FILTER_3X3_CLAMPED_MACROS_SVH
`define MEDIAN_FILTER_3X3_CLAMPED_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define MF3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MF3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mf3_pkg.sv -----
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 14;
    localparam int IMG_W_W = 13;
    localparam int IMG_H_W = 15;
    localparam int CFG_W   = 15;

    localparam int IMG_W_RESET = 4096;
    localparam int IMG_H_RESET = 4096;

    // Bit positions of the result kinds carried by a job.
    localparam int K_PREV_COL      = 0;  // centre one column back, row above
    localparam int K_END_COL       = 1;  // row end centre, row above
    localparam int K_PREV_COL_LAST = 2;  // centre one column back, last row
    localparam int K_END_COL_LAST  = 3;  // row end centre, last row
    localparam int KIND_N          = 4;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [CFG_W-1:0] cfg_data_t;

    // One window column, index 0 is the top row.
    typedef logic [2:0][PIX_W-1:0] column_t;
    // Window of three columns, index 0 is the oldest column.
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t           window;
        col_t              col;
        row_t              row;
        logic [KIND_N-1:0] kinds;
    } job_t;

    typedef struct packed {
        col_t col;
        row_t row;
        logic last;
        logic done;
    } res_meta_t;

endpackage

// ----- rtl/core/mf3_channels.sv -----
// Request channel interfaces for pixels in and median results out.
interface mf3_pixel_if;
    logic          valid;
    logic          ready;
    mf3_pkg::pix_t pixel_in;
    logic          frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface mf3_result_if;
    logic          valid;
    logic          ready;
    mf3_pkg::pix_t median_out;
    mf3_pkg::col_t out_col;
    mf3_pkg::row_t out_row;
    logic          last_of_run;
    logic          frame_done;

    modport source (output valid, output median_out, output out_col, output out_row,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input median_out, input out_col, input out_row,
                    input last_of_run, input frame_done, output ready);
endinterface

// ----- rtl/core/mf3_job_fifo.sv -----
// Short job queue between the window front end and the median back end.
`include "median_filter_3x3_clamped_macros.svh"
module mf3_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mf3_pkg::job_t              din,
    input  logic                       pop,
    output mf3_pkg::job_t              head,
    output logic                       head_valid,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mf3_pkg::job_t    entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    `MF3_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, count_reg < CNT_W'(DEPTH), "job queue overflow")
    `MF3_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, count_reg != '0, "job queue underflow")

endmodule

// ----- rtl/core/mf3_front.sv -----
// Front end: position counters, line stores, window and job classification.
`include "median_filter_3x3_clamped_macros.svh"
module mf3_front #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 16384,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  mf3_pkg::cfg_reg_t                cfg_index,
    input  mf3_pkg::cfg_data_t               cfg_data,
    mf3_pixel_if.sink                        pixel,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                             job_push,
    output mf3_pkg::job_t                    job
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OW    = CNT_W + 1;
    localparam logic [CW-1:0] RST_LAST_COL =
        CW'(((MAX_WIDTH < mf3_pkg::IMG_W_RESET) ? MAX_WIDTH : mf3_pkg::IMG_W_RESET) - 1);
    localparam logic [RW-1:0] RST_LAST_ROW =
        RW'(((MAX_HEIGHT < mf3_pkg::IMG_H_RESET) ? MAX_HEIGHT : mf3_pkg::IMG_H_RESET) - 1);

    function automatic logic [CW-1:0] col_limit(input logic [mf3_pkg::IMG_W_W-1:0] v);
        if (v == '0)
            return '0;
        else if (32'(v) > MAX_WIDTH)
            return CW'(MAX_WIDTH - 1);
        else
            return CW'(v - mf3_pkg::IMG_W_W'(1));
    endfunction

    function automatic logic [RW-1:0] row_limit(input logic [mf3_pkg::IMG_H_W-1:0] v);
        if (v == '0)
            return '0;
        else if (32'(v) > MAX_HEIGHT)
            return RW'(MAX_HEIGHT - 1);
        else
            return RW'(v - mf3_pkg::IMG_H_W'(1));
    endfunction

    // Line stores, one entry per column.
    mf3_pkg::pix_t upper_mem [MAX_WIDTH];
    mf3_pkg::pix_t lower_mem [MAX_WIDTH];

    logic [CW-1:0]     last_col_reg;
    logic [RW-1:0]     last_row_reg;
    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    mf3_pkg::window_t  window_reg;

    logic              b_valid_reg;
    logic [CW-1:0]     b_col_reg;
    logic [RW-1:0]     b_row_reg;
    mf3_pkg::pix_t     b_px_reg;
    logic              b_row_end_reg;
    logic              b_last_row_reg;
    logic              b_byp_reg;
    mf3_pkg::pix_t     byp_data_reg;
    mf3_pkg::pix_t     upper_rd_reg;
    mf3_pkg::pix_t     lower_rd_reg;

    logic              accept;
    logic [OW-1:0]     occupancy;
    logic [CW-1:0]     c_cur;
    logic [RW-1:0]     r_cur;
    logic              row_end_cur;
    logic              last_row_cur;
    logic              b_top;
    mf3_pkg::pix_t     upper_wdata;
    mf3_pkg::column_t  col_new;
    mf3_pkg::window_t  window_next;

    // Hold the input while the queue cannot take both pending jobs.
    assign occupancy   = OW'(q_count) + OW'(b_valid_reg);
    assign pixel.ready = (occupancy < OW'(QUEUE_DEPTH));
    assign accept      = pixel.valid && pixel.ready;

    assign c_cur        = pixel.frame_start ? '0 : col_reg;
    assign r_cur        = pixel.frame_start ? '0 : row_reg;
    assign row_end_cur  = (c_cur >= last_col_reg);
    assign last_row_cur = (r_cur >= last_row_reg);

    assign b_top       = (b_row_reg == '0);
    assign upper_wdata = b_top ? b_px_reg : lower_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lower_mem[c_cur] <= pixel.pixel_in;
            lower_rd_reg     <= lower_mem[c_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg <= upper_mem[c_cur];
        end
        if (b_valid_reg)
        begin
            upper_mem[b_col_reg] <= upper_wdata;
        end
    end

    // Stage B payload; forward the upper write when the next pixel hits the same column.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg      <= c_cur;
            b_row_reg      <= r_cur;
            b_px_reg       <= pixel.pixel_in;
            b_row_end_reg  <= row_end_cur;
            b_last_row_reg <= last_row_cur;
            b_byp_reg      <= b_valid_reg && (b_col_reg == c_cur);
            byp_data_reg   <= upper_wdata;
        end
    end

    always_comb
    begin
        col_new[0] = b_top ? b_px_reg : (b_byp_reg ? byp_data_reg : upper_rd_reg);
        col_new[1] = b_top ? b_px_reg : lower_rd_reg;
        col_new[2] = b_px_reg;
        if (b_col_reg == '0)
        begin
            window_next[0] = col_new;
            window_next[1] = col_new;
            window_next[2] = col_new;
        end
        else
        begin
            window_next[0] = window_reg[1];
            window_next[1] = window_reg[2];
            window_next[2] = col_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= RST_LAST_COL;
            last_row_reg <= RST_LAST_ROW;
            col_reg      <= '0;
            row_reg      <= '0;
            window_reg   <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mf3_pkg::REG_IMAGE_WIDTH:
                        last_col_reg <= col_limit(cfg_data[mf3_pkg::IMG_W_W-1:0]);
                    mf3_pkg::REG_IMAGE_HEIGHT:
                        last_row_reg <= row_limit(cfg_data[mf3_pkg::IMG_H_W-1:0]);
                    default:
                        ;
                endcase
            end
            if (accept)
            begin
                if (row_end_cur)
                begin
                    col_reg <= '0;
                    row_reg <= last_row_cur ? '0 : r_cur + RW'(1);
                end
                else
                begin
                    col_reg <= c_cur + CW'(1);
                    row_reg <= r_cur;
                end
            end
            if (b_valid_reg)
            begin
                window_reg <= window_next;
            end
            b_valid_reg <= accept;
        end
    end

    assign job_push   = b_valid_reg;
    assign job.window = window_next;
    assign job.col    = mf3_pkg::col_t'(b_col_reg);
    assign job.row    = mf3_pkg::row_t'(b_row_reg);
    assign job.kinds[mf3_pkg::K_PREV_COL]      = !b_top && (b_col_reg != '0);
    assign job.kinds[mf3_pkg::K_END_COL]       = !b_top && b_row_end_reg;
    assign job.kinds[mf3_pkg::K_PREV_COL_LAST] = b_last_row_reg && (b_col_reg != '0);
    assign job.kinds[mf3_pkg::K_END_COL_LAST]  = b_last_row_reg && b_row_end_reg;

    `MF3_ASSERT_NEXT(a_frame_start_origin, clk, rst_n, accept && pixel.frame_start, job_push && job.col == '0 && job.row == '0, "frame start did not restart at origin")

endmodule

// ----- rtl/core/mf3_back.sv -----
// Back end: result sequencer and pipelined 3x3 median network.
`include "median_filter_3x3_clamped_macros.svh"
module mf3_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mf3_pkg::job_t head,
    input  logic          head_valid,
    output logic          pop,
    mf3_result_if.source  result
);

    function automatic mf3_pkg::column_t sort3(input mf3_pkg::column_t v);
        mf3_pkg::pix_t   lo1;
        mf3_pkg::pix_t   hi1;
        mf3_pkg::pix_t   mid1;
        mf3_pkg::column_t s;
        lo1  = (v[0] < v[1]) ? v[0] : v[1];
        hi1  = (v[0] < v[1]) ? v[1] : v[0];
        s[2] = (hi1 > v[2]) ? hi1 : v[2];
        mid1 = (hi1 > v[2]) ? v[2] : hi1;
        s[0] = (lo1 < mid1) ? lo1 : mid1;
        s[1] = (lo1 < mid1) ? mid1 : lo1;
        return s;
    endfunction

    function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                           input mf3_pkg::pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [mf3_pkg::KIND_N-1:0] done_reg;
    logic [mf3_pkg::KIND_N-1:0] pending;
    logic [mf3_pkg::KIND_N-1:0] low;
    logic [mf3_pkg::KIND_N-1:0] rest;
    logic                       issue;
    logic                       end_cols;
    logic                       bottom;
    mf3_pkg::window_t           sel_win;
    mf3_pkg::res_meta_t         sel_meta;

    logic               s0_v_reg;
    mf3_pkg::window_t   s0_win_reg;
    mf3_pkg::res_meta_t s0_meta_reg;
    logic               s1_v_reg;
    mf3_pkg::window_t   s1_win_reg;
    mf3_pkg::res_meta_t s1_meta_reg;
    logic               s2_v_reg;
    mf3_pkg::column_t   s2_trio_reg;
    mf3_pkg::res_meta_t s2_meta_reg;
    logic               out_v_reg;
    mf3_pkg::pix_t      out_med_reg;
    mf3_pkg::res_meta_t out_meta_reg;

    logic go_out;
    logic go2;
    logic go1;
    logic go0;

    assign go_out = !out_v_reg || result.ready;
    assign go2    = !s2_v_reg || go_out;
    assign go1    = !s1_v_reg || go2;
    assign go0    = !s0_v_reg || go1;

    // Issue the lowest outstanding result kind of the head job.
    assign pending = head.kinds & ~done_reg;
    assign low     = pending & (~pending + mf3_pkg::KIND_N'(1));
    assign rest    = pending & ~low;
    assign issue   = head_valid && (pending != '0) && go0;
    assign pop     = head_valid && ((pending == '0) || (issue && (rest == '0)));

    assign end_cols = low[mf3_pkg::K_END_COL] || low[mf3_pkg::K_END_COL_LAST];
    assign bottom   = low[mf3_pkg::K_PREV_COL_LAST] || low[mf3_pkg::K_END_COL_LAST];

    always_comb
    begin
        mf3_pkg::column_t cv;
        logic [1:0]       src;
        for (int k = 0; k < 3; k++)
        begin
            if (end_cols)
                src = (k == 0) ? 2'd1 : 2'd2;
            else
                src = 2'(k);
            cv = head.window[src];
            sel_win[k] = bottom ? {cv[2], cv[2], cv[1]} : cv;
        end
        sel_meta.col  = end_cols ? head.col : head.col - mf3_pkg::col_t'(1);
        sel_meta.row  = bottom ? head.row : head.row - mf3_pkg::row_t'(1);
        sel_meta.last = (rest == '0);
        sel_meta.done = low[mf3_pkg::K_END_COL_LAST];
    end

    always_ff @(posedge clk)
    begin
        if (go0)
        begin
            s0_win_reg  <= sel_win;
            s0_meta_reg <= sel_meta;
        end
        if (go1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_win_reg[k] <= sort3(s0_win_reg[k]);
            end
            s1_meta_reg <= s0_meta_reg;
        end
        if (go2)
        begin
            s2_trio_reg[0] <= max2(max2(s1_win_reg[0][0], s1_win_reg[1][0]), s1_win_reg[2][0]);
            s2_trio_reg[1] <= med3(s1_win_reg[0][1], s1_win_reg[1][1], s1_win_reg[2][1]);
            s2_trio_reg[2] <= min2(min2(s1_win_reg[0][2], s1_win_reg[1][2]), s1_win_reg[2][2]);
            s2_meta_reg    <= s1_meta_reg;
        end
        if (go_out)
        begin
            out_med_reg  <= med3(s2_trio_reg[0], s2_trio_reg[1], s2_trio_reg[2]);
            out_meta_reg <= s2_meta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                done_reg <= '0;
            else if (issue)
                done_reg <= done_reg | low;
            if (go0)
                s0_v_reg <= issue;
            if (go1)
                s1_v_reg <= s0_v_reg;
            if (go2)
                s2_v_reg <= s1_v_reg;
            if (go_out)
                out_v_reg <= s2_v_reg;
        end
    end

    assign result.valid       = out_v_reg;
    assign result.median_out  = out_med_reg;
    assign result.out_col     = out_meta_reg.col;
    assign result.out_row     = out_meta_reg.row;
    assign result.last_of_run = out_meta_reg.last;
    assign result.frame_done  = out_meta_reg.done;

    `MF3_ASSERT_IMPLY(a_done_is_last, clk, rst_n, result.valid && result.frame_done, result.last_of_run, "frame done result is not last of its run")
    `MF3_ASSERT_IMPLY(a_issue_has_job, clk, rst_n, issue, head_valid && $onehot(low), "result issued without a single pending kind")

endmodule

// ----- rtl/core/median_filter_3x3_clamped.sv -----
// Streaming 3x3 median filter with edge clamping: top level.
// Path: an accepted pixel is registered in stage B and queued as a job; each of its results then
//   passes s0, s1, s2 and the output register. Throughput: one pixel per cycle while ready is high;
//   each line store takes one read and one write a pixel and the median pipeline one result a
//   cycle unless the output stalls, so 2 to 4 results hold the input once the queue fills.
// Reset: counters, window and valid bits clear, size returns to 4096 x 4096; line stores hold.
module median_filter_3x3_clamped #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 16384,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  mf3_pkg::cfg_reg_t  cfg_index,
    input  mf3_pkg::cfg_data_t cfg_data,
    mf3_pixel_if.sink          pixel,
    mf3_result_if.source       result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Front to queue: one job per accepted pixel, the cycle after the request.
    logic          job_push;
    mf3_pkg::job_t job;

    // Queue to back end.
    mf3_pkg::job_t    head;
    logic             head_valid;
    logic             pop;
    logic [CNT_W-1:0] q_count;

    // The front end tracks column and row, keeps two line stores and the window,
    // and tags each job with the result kinds it causes (up to four).
    mf3_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .q_count   (q_count),
        .job_push  (job_push),
        .job       (job)
    );

    // The queue lets the front keep taking pixels while the back end drains
    // the extra results at row ends and in the last row.
    mf3_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .din        (job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (q_count)
    );

    // The back end walks the job's result kinds in order and feeds a
    // four-stage median network that ends in the output register.
    mf3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- bench/mf3_check_pkg.sv -----
`timescale 1ns / 100ps
// Median predictor and result scoreboard used by the 3x3 median filter bench.
package mf3_check_pkg;

    localparam int unsigned FRAME_MAX_W = 4096;
    localparam int unsigned FRAME_MAX_H = 16384;

    typedef struct {
        mf3_pkg::pix_t median;
        mf3_pkg::col_t col;
        mf3_pkg::row_t row;
        logic last;
        logic done;
    } median_result_t;

    class median_tracker;
        mf3_pkg::pix_t upper_line[FRAME_MAX_W];
        mf3_pkg::pix_t lower_line[FRAME_MAX_W];
        mf3_pkg::pix_t win[9];     // [column*3 + row], column 0 oldest, row 0 top
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_reg;
        int unsigned height_reg;
        median_result_t awaited[$];
        int unsigned errors;
        int unsigned pixels;
        int unsigned checked;
        int unsigned frames;

        function new();
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = mf3_pkg::IMG_W_RESET;
            height_reg = mf3_pkg::IMG_H_RESET;
            errors     = 0;
            pixels     = 0;
            checked    = 0;
            frames     = 0;
        endfunction

        function void write_reg(mf3_pkg::cfg_reg_t idx, mf3_pkg::cfg_data_t val);
            if (idx == mf3_pkg::REG_IMAGE_WIDTH)
                width_reg = 32'(val[mf3_pkg::IMG_W_W-1:0]);
            else
                height_reg = 32'(val[mf3_pkg::IMG_H_W-1:0]);
        endfunction

        function mf3_pkg::pix_t median_of(mf3_pkg::pix_t v[9]);
            mf3_pkg::pix_t s[9];
            mf3_pkg::pix_t x;
            int i;
            int j;
            s = v;
            for (i = 1; i < 9; i++)
            begin
                x = s[i];
                j = i;
                while (j > 0 && s[j-1] > x)
                begin
                    s[j] = s[j-1];
                    j--;
                end
                s[j] = x;
            end
            return s[4];
        endfunction

        // bottom selects rows (mid, bot, bot): the clamped window of the last row
        function mf3_pkg::pix_t window_median(int c0, int c1, int c2, bit bottom);
            mf3_pkg::pix_t v[9];
            int cols[3];
            int k;
            int b;
            cols[0] = c0;
            cols[1] = c1;
            cols[2] = c2;
            for (k = 0; k < 3; k++)
            begin
                b = cols[k] * 3;
                if (bottom)
                begin
                    v[k*3]   = win[b+1];
                    v[k*3+1] = win[b+2];
                    v[k*3+2] = win[b+2];
                end
                else
                begin
                    v[k*3]   = win[b];
                    v[k*3+1] = win[b+1];
                    v[k*3+2] = win[b+2];
                end
            end
            return median_of(v);
        endfunction

        function void queue_median(mf3_pkg::pix_t m, int unsigned c, int unsigned r);
            median_result_t e;
            e.median = m;
            e.col    = mf3_pkg::col_t'(c);
            e.row    = mf3_pkg::row_t'(r);
            e.last   = 1'b0;
            e.done   = 1'b0;
            awaited.push_back(e);
        endfunction

        function void note_pixel(mf3_pkg::pix_t px, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned first;
            int k;
            mf3_pkg::pix_t top;
            mf3_pkg::pix_t mid;
            bit row_end;
            bit last_row;
            median_result_t tail;
            w = (width_reg == 0) ? 1 : width_reg;
            if (w > FRAME_MAX_W)
                w = FRAME_MAX_W;
            h = (height_reg == 0) ? 1 : height_reg;
            if (h > FRAME_MAX_H)
                h = FRAME_MAX_H;
            pixels++;
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            c = col_pos;
            r = row_pos;
            if (c >= FRAME_MAX_W)
                c = FRAME_MAX_W - 1;
            row_end  = (c >= w - 1);
            last_row = (r >= h - 1);

            // top row clamps upward: store it as both rows above
            if (r == 0)
            begin
                top = px;
                mid = px;
                upper_line[c] = px;
            end
            else
            begin
                top = upper_line[c];
                mid = lower_line[c];
                upper_line[c] = mid;
            end
            lower_line[c] = px;

            if (c == 0)
            begin
                for (k = 0; k < 3; k++)
                begin
                    win[k*3]   = top;
                    win[k*3+1] = mid;
                    win[k*3+2] = px;
                end
            end
            else
            begin
                for (k = 0; k < 6; k++)
                    win[k] = win[k+3];
                win[6] = top;
                win[7] = mid;
                win[8] = px;
            end

            first = awaited.size();
            if (r >= 1)
            begin
                if (c >= 1)
                    queue_median(window_median(0, 1, 2, 1'b0), c - 1, r - 1);
                if (row_end)
                    queue_median(window_median(1, 2, 2, 1'b0), c, r - 1);
            end
            if (last_row)
            begin
                if (c >= 1)
                    queue_median(window_median(0, 1, 2, 1'b1), c - 1, r);
                if (row_end)
                    queue_median(window_median(1, 2, 2, 1'b1), c, r);
            end
            if (awaited.size() > first)
            begin
                tail = awaited.pop_back();
                tail.last = 1'b1;
                tail.done = last_row && row_end;
                awaited.push_back(tail);
            end

            if (row_end)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(mf3_pkg::pix_t med, mf3_pkg::col_t col, mf3_pkg::row_t row,
                                   logic last, logic done);
            median_result_t e;
            if (awaited.size() == 0)
            begin
                $error("median %0d for col %0d row %0d arrived with none awaited",
                       med, col, row);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (e.done)
                frames++;
            check_field("median_out", 16'(e.median), 16'(med));
            check_field("out_col", 16'(e.col), 16'(col));
            check_field("out_row", 16'(e.row), 16'(row));
            check_field("last_of_run", 16'(e.last), 16'(last));
            check_field("frame_done", 16'(e.done), 16'(done));
        endfunction
    endclass

endpackage

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Top-level bench for median_filter_3x3_clamped: pixel driver, result checking, pacing.
module tb;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    // Result register sits behind stage B, the job queue and the median stages; leave a margin for the queue.
    localparam int unsigned IDLE_TAIL     = 12;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned RANDOM_PIXELS = 230;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en;
    mf3_pkg::cfg_reg_t  cfg_index;
    mf3_pkg::cfg_data_t cfg_data;

    mf3_pixel_if  pixel_ch ();
    mf3_result_if result_ch ();

    mf3_check_pkg::median_tracker tracker;

    // Pacing controls shared between the pixel driver and the result pacing.
    bit gaps_on;
    bit hold_results;

    int unsigned cycle_count = 0;

    median_filter_3x3_clamped dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end the run with an error once the cycle count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d medians still awaited",
                     cycle_count, tracker.awaited.size());
            $display("[median_filter_3x3_clamped] ERROR");
            $finish;
        end
    end

    // Check each result request at the edge that accepts it; values read here are
    // the ones held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.check_result(result_ch.median_out, result_ch.out_col, result_ch.out_row,
                                 result_ch.last_of_run, result_ch.frame_done);
    end

    // Mostly no gap, some short ones, a few long ones; none at all when gaps are off.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix extremes, a flat patch with noise (meaningful medians) and full random.
    function automatic mf3_pkg::pix_t pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3, 4: return mf3_pkg::pix_t'($urandom_range(100, 140));
            default: return mf3_pkg::pix_t'($urandom);
        endcase
    endfunction

    // Result pacing: hold ready in runs, drop it for random stalls, and honor a
    // long hold-off request from the stimulus so the block backs up.
    initial
    begin : result_pacing
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                stall = pick_gap();
                if (stall == 0)
                    stall = 1;
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Offer one pixel request, hold it until accepted, then note it and idle a while.
    // With no gap the next call raises valid again in the acceptance step itself.
    task automatic send_pixel(input mf3_pkg::pix_t px, input logic fs);
        int unsigned gap;
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pixel_in    <= px;
        pixel_ch.frame_start <= fs;
        @(posedge clk);
        while (pixel_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.note_pixel(px, fs);
        gap = pick_gap();
        if (gap != 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a run of random pixels; start marks the first one as a frame start and
    // noisy scatters stray frame starts through the run.
    task automatic send_run(input int unsigned count, input bit start, input bit noisy);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_pixel(pick_pixel(),
                       (i == 0 && start) || (noisy && $urandom_range(0, 39) == 0));
    endtask

    // Write both frame size registers on consecutive edges; write enable stays high
    // across the pair.
    task automatic set_frame(input int unsigned w, input int unsigned h);
        cfg_wr_en <= 1'b1;
        cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= mf3_pkg::cfg_data_t'(w);
        @(posedge clk);
        cfg_index <= mf3_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= mf3_pkg::cfg_data_t'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.write_reg(mf3_pkg::REG_IMAGE_WIDTH, mf3_pkg::cfg_data_t'(w));
        tracker.write_reg(mf3_pkg::REG_IMAGE_HEIGHT, mf3_pkg::cfg_data_t'(h));
    endtask

    // Drop valid, wait for every awaited median, then let the pipeline drain pixels
    // that cause no result (top rows) before anything else happens.
    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned ew;
        int unsigned eh;
        int unsigned f;
        int unsigned frame_count;
        int unsigned len;
        int unsigned random_sent;
        mf3_pkg::pix_t directed_px[12];

        tracker = new();
        cfg_wr_en            <= 1'b0;
        cfg_index            <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_data             <= '0;
        pixel_ch.valid       <= 1'b0;
        pixel_ch.pixel_in    <= '0;
        pixel_ch.frame_start <= 1'b0;
        gaps_on      = 1'b0;
        hold_results = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed 4x3 frame: extremes, alternating bit patterns and near-ties.
        directed_px = '{8'd0, 8'd255, 8'd0, 8'd255,
                        8'h55, 8'hAA, 8'h0F, 8'hF0,
                        8'd1, 8'd128, 8'd254, 8'd127};
        set_frame(4, 3);
        foreach (directed_px[i])
            send_pixel(directed_px[i], i == 0);
        wait_idle();

        // Zero sizes count as one: every pixel is a 1x1 frame of its own.
        set_frame(0, 0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h81, 1'b0);
        wait_idle();

        // Random phases of small frames. The first pixel after a size change is
        // always a frame start, so a grown width never reads an unwritten column.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            ew = (w == 0) ? 1 : w;
            eh = (h == 0) ? 1 : h;
            gaps_on = ($urandom_range(0, 3) != 0);
            set_frame(w, h);
            frame_count = $urandom_range(1, 3);
            for (f = 0; f < frame_count; f++)
            begin
                len = ew * eh;
                // cut a frame short now and then
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, len);
                send_run(len, f == 0 || $urandom_range(0, 1) == 1, 1'b1);
                random_sent += len;
            end
            wait_idle();
        end

        // Hold off the results while the pixel stream keeps coming, so the job
        // queue fills and the input stalls; then pause until all medians are back
        // and finish the frame.
        gaps_on = 1'b0;
        set_frame(5, 8);
        hold_results = 1'b1;
        send_run(30, 1'b1, 1'b0);
        wait_idle();
        send_run(10, 1'b0, 1'b0);
        wait_idle();

        // Shrink the frame mid-way: stop at column 3 of row 3 in a 7-wide frame of
        // saturated height, then narrow to 2x3 so that column counts as the row end
        // and row 3 as the last row; the counters then wrap to a fresh 2x3 frame.
        gaps_on = 1'b1;
        set_frame(7, 32767);
        send_run(24, 1'b1, 1'b0);
        wait_idle();
        set_frame(2, 3);
        send_run(7, 1'b0, 1'b0);
        wait_idle();

        // Oversized width: 8191 saturates to 4096 columns, one row, so the first
        // columns of a single last row come out with no row end.
        gaps_on = 1'b0;
        set_frame(8191, 1);
        send_run(6, 1'b1, 1'b0);
        wait_idle();

        // Exact upper register values; top-row pixels only, which yield nothing.
        set_frame(4096, 16384);
        send_run(5, 1'b1, 1'b0);
        wait_idle();

        $display("run covered %0d pixels and %0d checked medians over %0d finished frames",
                 tracker.pixels, tracker.checked, tracker.frames);
        $display("sizes from 1x1 to small frames, saturated sizes, mid-frame shrink, hold-off");
        if (tracker.errors == 0)
            $display("[median_filter_3x3_clamped] OK");
        else
            $display("[median_filter_3x3_clamped] ERROR");
        $finish;
    end

endmodule
